### rtl/kmsh_pkg.sv
// Package for the key matrix scanner: types, constants and the key code ROM.
`default_nettype none
package kmsh_pkg;

    localparam int ROWS_DEF  = 7;
    localparam int COLS_DEF  = 16;
    localparam int REPORT_BYTES_DEF = 8;
    localparam int TBL_ROWS  = 7;
    localparam int TBL_COLS  = 16;
    localparam int NORMAL_SLOTS = 6;

    localparam logic [6:0] MAX_TOTAL_RESET  = 7'd14;
    localparam logic [2:0] MAX_NORMAL_RESET = 3'd6;

    localparam logic [0:0] REG_MAX_TOTAL  = 1'b0;
    localparam logic [0:0] REG_MAX_NORMAL = 1'b1;

    localparam logic [3:0] MOD_NIBBLE = 4'he;

    typedef struct packed {
        logic [2:0]  row;
        logic [15:0] first_sample;
        logic [15:0] second_sample;
    } in_item_t;

    typedef struct packed {
        logic [7:0] modifiers;
        logic [7:0] reserved_byte;
        logic [7:0] key_slot_one;
        logic [7:0] key_slot_two;
        logic [7:0] key_slot_three;
        logic [7:0] key_slot_four;
        logic [7:0] key_slot_five;
        logic [7:0] key_slot_six;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WALK,
        ST_FINISH,
        ST_OUT
    } state_t;

    // Position table (pos_index) and HID code table (hid_code), as two separate lookups.
    function automatic logic [7:0] pos_index(input logic [2:0] r, input logic [3:0] c);
        logic [7:0] v;
        v = 8'd0;
        case ({r, c})
            7'h00: v = 8'd1;   7'h01: v = 8'd112; 7'h02: v = 8'd113; 7'h03: v = 8'd6;
            7'h04: v = 8'd7;   7'h05: v = 8'd13;  7'h06: v = 8'd119; 7'h07: v = 8'd80;
            7'h08: v = 8'd85;  7'h09: v = 8'd75;  7'h0a: v = 8'd76;  7'h0c: v = 8'd120;
            7'h0d: v = 8'd12;  7'h0f: v = 8'd58;
            7'h10: v = 8'd131; 7'h11: v = 8'd132; 7'h12: v = 8'd133; 7'h13: v = 8'd50;
            7'h14: v = 8'd51;  7'h15: v = 8'd56;  7'h16: v = 8'd129; 7'h17: v = 8'd79;
            7'h18: v = 8'd105; 7'h19: v = 8'd89;  7'h1a: v = 8'd84;  7'h1c: v = 8'd123;
            7'h1d: v = 8'd55;  7'h1e: v = 8'd62;
            7'h20: v = 8'd46;  7'h21: v = 8'd47;  7'h22: v = 8'd48;  7'h23: v = 8'd49;
            7'h24: v = 8'd52;  7'h25: v = 8'd53;  7'h26: v = 8'd54;  7'h28: v = 8'd100;
            7'h29: v = 8'd95;  7'h2a: v = 8'd90;  7'h2c: v = 8'd43;  7'h2d: v = 8'd42;
            7'h2f: v = 8'd64;
            7'h30: v = 8'd110; 7'h31: v = 8'd45;  7'h32: v = 8'd115; 7'h33: v = 8'd35;
            7'h34: v = 8'd36;  7'h35: v = 8'd117; 7'h37: v = 8'd83;  7'h38: v = 8'd104;
            7'h39: v = 8'd99;  7'h3a: v = 8'd61;  7'h3c: v = 8'd122; 7'h3d: v = 8'd41;
            7'h3e: v = 8'd60;
            7'h40: v = 8'd31;  7'h41: v = 8'd32;  7'h42: v = 8'd33;  7'h43: v = 8'd34;
            7'h44: v = 8'd37;  7'h45: v = 8'd38;  7'h46: v = 8'd39;  7'h47: v = 8'd108;
            7'h48: v = 8'd103; 7'h49: v = 8'd98;  7'h4a: v = 8'd93;  7'h4b: v = 8'd57;
            7'h4c: v = 8'd29;  7'h4d: v = 8'd40;  7'h4e: v = 8'd59;
            7'h50: v = 8'd16;  7'h51: v = 8'd30;  7'h52: v = 8'd114; 7'h53: v = 8'd21;
            7'h54: v = 8'd22;  7'h55: v = 8'd28;  7'h56: v = 8'd118; 7'h57: v = 8'd107;
            7'h58: v = 8'd102; 7'h59: v = 8'd97;  7'h5a: v = 8'd92;  7'h5b: v = 8'd44;
            7'h5c: v = 8'd15;  7'h5d: v = 8'd27;
            7'h60: v = 8'd17;  7'h61: v = 8'd18;  7'h62: v = 8'd19;  7'h63: v = 8'd20;
            7'h64: v = 8'd23;  7'h65: v = 8'd24;  7'h66: v = 8'd25;  7'h67: v = 8'd106;
            7'h68: v = 8'd101; 7'h69: v = 8'd96;  7'h6a: v = 8'd91;  7'h6c: v = 8'd14;
            7'h6d: v = 8'd26;  7'h6e: v = 8'd125; 7'h6f: v = 8'd126;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] hid_code(input logic [7:0] p);
        logic [7:0] v;
        v = 8'h00;
        case (p)
            8'd1: v = 8'h35;   8'd2: v = 8'h1e;   8'd3: v = 8'h1f;   8'd4: v = 8'h20;
            8'd5: v = 8'h21;   8'd6: v = 8'h22;   8'd7: v = 8'h23;   8'd8: v = 8'h24;
            8'd9: v = 8'h25;   8'd10: v = 8'h26;  8'd11: v = 8'h27;  8'd12: v = 8'h2d;
            8'd13: v = 8'h2e;  8'd15: v = 8'h2a;  8'd16: v = 8'h2b;  8'd17: v = 8'h14;
            8'd18: v = 8'h1a;  8'd19: v = 8'h08;  8'd20: v = 8'h15;  8'd21: v = 8'h17;
            8'd22: v = 8'h1c;  8'd23: v = 8'h18;  8'd24: v = 8'h0c;  8'd25: v = 8'h12;
            8'd26: v = 8'h13;  8'd27: v = 8'h2f;  8'd28: v = 8'h30;  8'd29: v = 8'h31;
            8'd30: v = 8'h39;  8'd31: v = 8'h04;  8'd32: v = 8'h16;  8'd33: v = 8'h07;
            8'd34: v = 8'h09;  8'd35: v = 8'h0a;  8'd36: v = 8'h0b;  8'd37: v = 8'h0d;
            8'd38: v = 8'h0e;  8'd39: v = 8'h0f;  8'd40: v = 8'h33;  8'd41: v = 8'h34;
            8'd43: v = 8'h28;  8'd44: v = 8'he1;  8'd46: v = 8'h1d;  8'd47: v = 8'h1b;
            8'd48: v = 8'h06;  8'd49: v = 8'h19;  8'd50: v = 8'h05;  8'd51: v = 8'h11;
            8'd52: v = 8'h10;  8'd53: v = 8'h36;  8'd54: v = 8'h37;  8'd55: v = 8'h38;
            8'd57: v = 8'he1;  8'd58: v = 8'he4;  8'd59: v = 8'hff;  8'd60: v = 8'he2;
            8'd61: v = 8'h2c;  8'd62: v = 8'he6;  8'd64: v = 8'he4;  8'd75: v = 8'h49;
            8'd76: v = 8'h4c;  8'd79: v = 8'h50;  8'd83: v = 8'h52;  8'd84: v = 8'h51;
            8'd89: v = 8'h4f;  8'd90: v = 8'h53;  8'd91: v = 8'h24;  8'd92: v = 8'h21;
            8'd93: v = 8'h1e;  8'd95: v = 8'h54;  8'd96: v = 8'h25;  8'd97: v = 8'h22;
            8'd98: v = 8'h1f;  8'd99: v = 8'h27;  8'd100: v = 8'h55; 8'd101: v = 8'h26;
            8'd102: v = 8'h23; 8'd103: v = 8'h20; 8'd104: v = 8'h36; 8'd105: v = 8'h56;
            8'd106: v = 8'h57; 8'd108: v = 8'h2a; 8'd110: v = 8'h2a; 8'd112: v = 8'h3a;
            8'd113: v = 8'h3b; 8'd114: v = 8'h3c; 8'd115: v = 8'h3d; 8'd116: v = 8'h3e;
            8'd117: v = 8'h3f; 8'd118: v = 8'h40; 8'd119: v = 8'h41; 8'd120: v = 8'h42;
            8'd121: v = 8'h43; 8'd122: v = 8'h68; 8'd123: v = 8'h69; 8'd124: v = 8'h46;
            8'd127: v = 8'he3; 8'd129: v = 8'h65;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/kmsh_ghost_check.sv
// Ghost test for one candidate key against the keys already taken this frame and the key limits.
`default_nettype none
module kmsh_ghost_check #(
    parameter int ROWS = kmsh_pkg::ROWS_DEF,
    parameter int COLS = kmsh_pkg::COLS_DEF,
    parameter int RW   = (ROWS > 1) ? $clog2(ROWS) : 1,
    parameter int CW   = (COLS > 1) ? $clog2(COLS) : 1
) (
    input  wire logic [ROWS-1:0][COLS-1:0] key_map,
    input  wire logic [RW-1:0]             r,
    input  wire logic [CW-1:0]             c,
    input  wire logic [6:0]                map_count,
    input  wire logic [6:0]                total_keys,
    input  wire logic [2:0]                normal_keys,
    input  wire logic [6:0]                max_total,
    input  wire logic [2:0]                max_normal,
    output logic                           ghost
);
    logic [COLS-1:0] cbit;
    logic [COLS-1:0] row_map;
    logic [COLS-1:0] above_or;
    logic [COLS-1:0] lower_cols;
    logic            rect_a;
    logic            col_hit_above;

    always_comb begin
        cbit     = COLS'(1) << c;
        row_map  = key_map[r];
        above_or = '0;
        rect_a   = 1'b0;
        col_hit_above = 1'b0;
        for (int i = 0; i < ROWS; i++) begin
            if (RW'(i) < r) begin
                above_or = above_or | key_map[i];
                if ((key_map[i] & cbit) != '0) begin
                    col_hit_above = 1'b1;
                    if (((key_map[i] | row_map) & ~cbit) != '0) begin
                        rect_a = 1'b1;
                    end
                end
            end
        end
        lower_cols = cbit - COLS'(1);
        ghost = 1'b0;
        if (map_count >= 7'd2) begin
            if (total_keys > max_total || normal_keys > max_normal) begin
                ghost = 1'b1;
            end else if (rect_a) begin
                ghost = 1'b1;
            end else if ((row_map & lower_cols) != '0) begin
                if (((row_map & lower_cols & above_or) != '0) || col_hit_above) begin
                    ghost = 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

### rtl/key_matrix_scan_to_hid_report_top.sv
// Top level of the key matrix scanner that builds HID boot keyboard reports.
// Each row beat passes the accepting idle state, one load state, one walk step per column
// through the shared ghost/key unit and one finish state; only idle takes a new beat. The
// finish state loads the output register while no earlier report is held, untaken; on
// the closing row it also compares the report and waits there while one is held, untaken.
`default_nettype none
module key_matrix_scan_to_hid_report_top #(
    parameter int ROWS = kmsh_pkg::ROWS_DEF,
    parameter int COLS = kmsh_pkg::COLS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire kmsh_pkg::in_item_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output kmsh_pkg::out_item_t     m_data,
    input  wire logic               cfg_we,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [6:0]         cfg_data
);
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;

    kmsh_pkg::state_t state_reg, state_next;

    logic [6:0] max_total_reg;
    logic [2:0] max_normal_reg;
    logic [ROWS-1:0][COLS-1:0] deb_reg;
    logic [ROWS-1:0][COLS-1:0] map_reg, map_next;
    logic [6:0] map_count_reg, map_count_next;
    logic [6:0] total_reg, total_next;
    logic [2:0] normal_reg, normal_next;
    logic [7:0] mods_reg, mods_next;
    logic [5:0][7:0] slots_reg, slots_next;
    logic       ghost_seen_reg, ghost_seen_next;
    logic [63:0] last_reg;
    logic [2:0]  row_in_reg;
    logic [15:0] first_reg, second_reg;
    logic [COLS-1:0] v_reg, v_next;
    logic [CW-1:0] col_reg, col_next;
    kmsh_pkg::out_item_t out_reg;
    logic m_valid_reg;

    logic [RW-1:0] r;
    logic ghost;
    logic [7:0] code;
    logic [2:0] limit;
    logic [63:0] packed_rep;
    logic [COLS-1:0] vin;
    logic [COLS-1:0] drow;
    logic [2:0] lrow;
    logic [3:0] lcol;

    assign r = row_in_reg[RW-1:0];
    assign s_ready = (state_reg == kmsh_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    kmsh_ghost_check #(.ROWS(ROWS), .COLS(COLS), .RW(RW), .CW(CW)) u_ghost (
        .key_map    (map_reg),
        .r          (r),
        .c          (col_reg),
        .map_count  (map_count_reg),
        .total_keys (total_reg),
        .normal_keys(normal_reg),
        .max_total  (max_total_reg),
        .max_normal (max_normal_reg),
        .ghost      (ghost)
    );

    always_comb begin
        lrow = 3'(r);
        lcol = 4'(col_reg);
        if (int'(r) >= kmsh_pkg::TBL_ROWS) begin
            code = 8'h00;
        end else begin
            code = kmsh_pkg::hid_code(kmsh_pkg::pos_index(lrow, lcol));
        end
        limit = (max_normal_reg < 3'(kmsh_pkg::NORMAL_SLOTS)) ? max_normal_reg
                                                           : 3'(kmsh_pkg::NORMAL_SLOTS);
        packed_rep = {slots_reg[5], slots_reg[4], slots_reg[3], slots_reg[2],
                      slots_reg[1], slots_reg[0], 8'h00, mods_reg};
        vin  = ~first_reg[COLS-1:0];
        drow = deb_reg[r];
    end

    always_comb begin
        state_next      = state_reg;
        map_next        = map_reg;
        map_count_next  = map_count_reg;
        total_next      = total_reg;
        normal_next     = normal_reg;
        mods_next       = mods_reg;
        slots_next      = slots_reg;
        ghost_seen_next = ghost_seen_reg;
        v_next          = v_reg;
        col_next        = col_reg;
        case (state_reg)
            kmsh_pkg::ST_IDLE: begin
                col_next = '0;
                if (s_valid && int'(s_data.row) < ROWS) begin
                    state_next = kmsh_pkg::ST_LOAD;
                end
            end
            kmsh_pkg::ST_LOAD: begin
                if (vin != drow && first_reg != second_reg) begin
                    v_next = drow;
                end else begin
                    v_next = vin;
                end
                state_next = kmsh_pkg::ST_WALK;
            end
            kmsh_pkg::ST_WALK: begin
                if (v_reg[col_reg]) begin
                    if (ghost) begin
                        ghost_seen_next = 1'b1;
                    end else if (code[7:4] == kmsh_pkg::MOD_NIBBLE ||
                                 normal_reg < limit) begin
                        if (code[7:4] == kmsh_pkg::MOD_NIBBLE) begin
                            if (!code[3]) begin
                                mods_next = mods_reg | (8'd1 << code[2:0]);
                            end
                        end else begin
                            slots_next[normal_reg] = code;
                            normal_next = normal_reg + 3'd1;
                        end
                        map_next[r][col_reg] = 1'b1;
                        map_count_next = map_count_reg + 7'd1;
                        total_next     = total_reg + 7'd1;
                    end else begin
                        ghost_seen_next = 1'b1;
                    end
                end
                if (int'(col_reg) == COLS - 1) begin
                    state_next = kmsh_pkg::ST_FINISH;
                end else begin
                    col_next = col_reg + CW'(1);
                end
            end
            kmsh_pkg::ST_FINISH: begin
                if (int'(r) == ROWS - 1) begin
                    if (!m_valid_reg || m_ready) begin
                        state_next      = kmsh_pkg::ST_IDLE;
                        map_next        = '0;
                        map_count_next  = '0;
                        total_next      = '0;
                        normal_next     = '0;
                        mods_next       = '0;
                        slots_next      = '0;
                        ghost_seen_next = 1'b0;
                    end
                end else begin
                    state_next = kmsh_pkg::ST_IDLE;
                end
            end
            default: state_next = kmsh_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= kmsh_pkg::ST_IDLE;
            max_total_reg  <= kmsh_pkg::MAX_TOTAL_RESET;
            max_normal_reg <= kmsh_pkg::MAX_NORMAL_RESET;
            deb_reg        <= '0;
            map_reg        <= '0;
            map_count_reg  <= '0;
            total_reg      <= '0;
            normal_reg     <= '0;
            mods_reg       <= '0;
            slots_reg      <= '0;
            ghost_seen_reg <= 1'b0;
            last_reg       <= '0;
            m_valid_reg    <= 1'b0;
            col_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            map_reg        <= map_next;
            map_count_reg  <= map_count_next;
            total_reg      <= total_next;
            normal_reg     <= normal_next;
            mods_reg       <= mods_next;
            slots_reg      <= slots_next;
            ghost_seen_reg <= ghost_seen_next;
            col_reg        <= col_next;
            if (cfg_we) begin
                if (cfg_index == kmsh_pkg::REG_MAX_TOTAL) begin
                    max_total_reg <= cfg_data;
                end else begin
                    max_normal_reg <= cfg_data[2:0];
                end
            end
            if (state_reg == kmsh_pkg::ST_LOAD && vin != drow && first_reg == second_reg) begin
                deb_reg[r] <= vin;
            end
            if (state_reg == kmsh_pkg::ST_FINISH && int'(r) == ROWS - 1 &&
                (!m_valid_reg || m_ready) && !ghost_seen_reg && packed_rep != last_reg) begin
                last_reg    <= packed_rep;
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        v_reg <= v_next;
        if (s_valid && s_ready) begin
            row_in_reg <= s_data.row;
            first_reg  <= s_data.first_sample;
            second_reg <= s_data.second_sample;
        end
        if (state_reg == kmsh_pkg::ST_FINISH && (!m_valid_reg || m_ready)) begin
            out_reg.modifiers      <= mods_reg;
            out_reg.reserved_byte  <= 8'h00;
            out_reg.key_slot_one   <= slots_reg[0];
            out_reg.key_slot_two   <= slots_reg[1];
            out_reg.key_slot_three <= slots_reg[2];
            out_reg.key_slot_four  <= slots_reg[3];
            out_reg.key_slot_five  <= slots_reg[4];
            out_reg.key_slot_six   <= slots_reg[5];
        end
    end
endmodule
`default_nettype wire

### rtl/kmsh_checker.sv
// Port-level checker for the key matrix scanner, bound to the top level.
`default_nettype none
module kmsh_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire kmsh_pkg::in_item_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire kmsh_pkg::out_item_t m_data
);
    // The reserved byte of every report beat is zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.reserved_byte == 8'h00)
        else $error("reserved byte not zero");

    // A row beat inside the matrix keeps the block busy for the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && int'(s_data.row) < kmsh_pkg::ROWS_DEF) |=> !s_ready)
        else $error("ready right after accept");

    // A pending report beat holds until taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_data))
        else $error("report dropped or changed");

    // A report only shows up after the block has been busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("report without work");
endmodule

bind key_matrix_scan_to_hid_report_top kmsh_checker u_kmsh_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
`default_nettype wire
